### sv/assert_macros.svh
// Assertion helpers used by line_intersection_times_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check on every rising clock edge outside of reset.
`define LIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check on every rising clock edge, reset included.
`define LIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LIT_ASSERT(lbl, prop, msg)
`define LIT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### sv/lit_pkg.sv
package lit_pkg;

  // Coordinate format
  localparam int CW   = 32;
  localparam int FB   = 16;
  localparam int TOLW = 16;

  // Internal widths
  localparam int PW  = 2 * CW - FB;   // floored product of two coordinates
  localparam int XW  = PW + 1;        // cross component
  localparam int DW  = CW + 1;        // origin difference
  localparam int NPW = CW + DW - FB;  // floored product coordinate * difference
  localparam int NW  = NPW + 1;       // numerator
  localparam int QB  = CW - 1;        // quotient bits below the saturation point

  // Pipeline depth
  localparam int DIV_LAT = QB + 3;
  localparam int PRE_ST  = 5;
  localparam int POST_ST = 4;
  localparam int NST     = PRE_ST + DIV_LAT + POST_ST;

  localparam logic [TOLW-1:0] TOL_RST = 16'd16;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t dax;
    coord_t day;
    coord_t daz;
    coord_t oax;
    coord_t oay;
    coord_t oaz;
    coord_t dbx;
    coord_t dby;
    coord_t dbz;
    coord_t obx;
    coord_t oby;
    coord_t obz;
  } pair_t;

  // Denominator choice
  typedef enum logic [1:0] {
    SEL_Z,
    SEL_Y,
    SEL_X,
    SEL_PAR
  } sel_e;

endpackage

### sv/lit_div.sv
module lit_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [lit_pkg::NW-1:0] num_i,
  input  logic signed [lit_pkg::XW-1:0] den_i,
  output logic signed [lit_pkg::CW-1:0] quo_o
);

  localparam int NW = lit_pkg::NW;
  localparam int XW = lit_pkg::XW;
  localparam int QB = lit_pkg::QB;
  localparam int FB = lit_pkg::FB;
  localparam int CW = lit_pkg::CW;
  localparam int SH = QB - FB;

  logic [NW-1:0] un_q;
  logic [XW-1:0] ud_a_q;
  logic          neg_a_q;

  logic [XW-1:0] r_q   [QB+1];
  logic [QB-1:0] q_q   [QB+1];
  logic [QB-1:0] dl_q  [QB+1];
  logic [XW-1:0] ud_q  [QB+1];
  logic          neg_q [QB+1];
  logic          ovf_q [QB+1];

  logic [CW-1:0] qz;
  logic [CW-1:0] quo_d;

  // Take magnitudes and the result sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      un_q    <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      ud_a_q  <= den_i[XW-1] ? XW'(-den_i) : XW'(den_i);
      neg_a_q <= num_i[NW-1] ^ den_i[XW-1];
    end
  end

  // Detect saturation and load the first partial remainder
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= {{(XW+SH-NW){1'b0}}, un_q} >= {ud_a_q, {SH{1'b0}}};
      r_q[0]   <= XW'(un_q >> SH);
      dl_q[0]  <= {un_q[SH-1:0], {FB{1'b0}}};
      q_q[0]   <= '0;
      ud_q[0]  <= ud_a_q;
      neg_q[0] <= neg_a_q;
    end
  end

  // One restoring step per stage
  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [XW:0] rs;
    logic        ge;

    always_comb begin
      rs = {r_q[s], dl_q[s][QB-1]};
      ge = rs >= {1'b0, ud_q[s]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1]   <= ge ? XW'(rs - {1'b0, ud_q[s]}) : rs[XW-1:0];
        q_q[s+1]   <= {q_q[s][QB-2:0], ge};
        dl_q[s+1]  <= {dl_q[s][QB-2:0], 1'b0};
        ud_q[s+1]  <= ud_q[s];
        neg_q[s+1] <= neg_q[s];
        ovf_q[s+1] <= ovf_q[s];
      end
    end
  end

  // Apply sign and saturate
  always_comb begin
    qz = {1'b0, q_q[QB]};
    if (ovf_q[QB]) begin
      quo_d = neg_q[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    end else begin
      quo_d = neg_q[QB] ? -qz : qz;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= $signed(quo_d);
    end
  end

endmodule

### sv/line_intersection_times_unit.sv
// Meeting parameters of two 3D lines, signed Q16.16.
//
// Input channel: valid_i / stall_o with one line pair (direction and origin of
// lines a and b). Output channel: valid_o / stall_i with meets_o, time_a_o and
// time_b_o; both times read zero when meets_o is low.
// A transfer happens on a rising edge with valid high and stall low.
// cfg_we_i writes cfg_data_i into the tolerance register; write it only while
// no transfer is in flight.
//
// From input transfer to result valid a pair passes five stages for the cross
// product, denominator choice and numerators, 34 for the two bit-per-stage
// dividers (one quotient bit each), four to rebuild and compare the points.
// Throughput is one pair per cycle while no result is stalled at the output.
// While a result is stalled at the output the whole pipeline holds and
// stall_o is raised; with no result waiting the pipeline advances even if
// stall_i is high.
// Reset clears all valid bits and loads tolerance with 16.
`include "assert_macros.svh"

module line_intersection_times_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lit_pkg::TOLW-1:0]        cfg_data_i,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic signed [lit_pkg::CW-1:0]   dir_a_x_i,
  input  logic signed [lit_pkg::CW-1:0]   dir_a_y_i,
  input  logic signed [lit_pkg::CW-1:0]   dir_a_z_i,
  input  logic signed [lit_pkg::CW-1:0]   org_a_x_i,
  input  logic signed [lit_pkg::CW-1:0]   org_a_y_i,
  input  logic signed [lit_pkg::CW-1:0]   org_a_z_i,
  input  logic signed [lit_pkg::CW-1:0]   dir_b_x_i,
  input  logic signed [lit_pkg::CW-1:0]   dir_b_y_i,
  input  logic signed [lit_pkg::CW-1:0]   dir_b_z_i,
  input  logic signed [lit_pkg::CW-1:0]   org_b_x_i,
  input  logic signed [lit_pkg::CW-1:0]   org_b_y_i,
  input  logic signed [lit_pkg::CW-1:0]   org_b_z_i,
  output logic                            valid_o,
  input  logic                            stall_i,
  output logic                            meets_o,
  output logic signed [lit_pkg::CW-1:0]   time_a_o,
  output logic signed [lit_pkg::CW-1:0]   time_b_o
);

  localparam int CW   = lit_pkg::CW;
  localparam int FB   = lit_pkg::FB;
  localparam int TOLW = lit_pkg::TOLW;
  localparam int PW   = lit_pkg::PW;
  localparam int XW   = lit_pkg::XW;
  localparam int DW   = lit_pkg::DW;
  localparam int NPW  = lit_pkg::NPW;
  localparam int NW   = lit_pkg::NW;
  localparam int NST  = lit_pkg::NST;
  localparam int DOUT = lit_pkg::PRE_ST + lit_pkg::DIV_LAT;
  localparam int IT_N = DOUT + 1;
  localparam int PA_N = NST - 3;

  logic en;
  logic [TOLW-1:0] tol_q;
  logic [NST-1:0]  vld_q;

  lit_pkg::pair_t in_item;
  lit_pkg::pair_t itm_q [IT_N];
  logic           par_q [PA_N];

  // Pipeline advance
  assign en      = !vld_q[NST-1] || !stall_i;
  assign stall_o = !en;
  assign valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= lit_pkg::TOL_RST;
    end else if (cfg_we_i) begin
      tol_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  assign in_item = '{dax: dir_a_x_i, day: dir_a_y_i, daz: dir_a_z_i,
                     oax: org_a_x_i, oay: org_a_y_i, oaz: org_a_z_i,
                     dbx: dir_b_x_i, dby: dir_b_y_i, dbz: dir_b_z_i,
                     obx: org_b_x_i, oby: org_b_y_i, obz: org_b_z_i};

  // Carry the line pair along the pipeline
  always_ff @(posedge clk_i) begin
    if (en) begin
      itm_q[0] <= in_item;
      for (int k = 1; k < IT_N; k++) begin
        itm_q[k] <= itm_q[k-1];
      end
    end
  end

  // Stage 1: cross products and origin differences
  logic signed [2*CW-1:0] cp [6];
  logic [PW-1:0] xp_q [6];
  logic signed [DW-1:0] od_q [3];

  always_comb begin
    cp[0] = dir_a_x_i * dir_b_y_i;
    cp[1] = dir_a_y_i * dir_b_x_i;
    cp[2] = dir_a_z_i * dir_b_x_i;
    cp[3] = dir_a_x_i * dir_b_z_i;
    cp[4] = dir_a_y_i * dir_b_z_i;
    cp[5] = dir_a_z_i * dir_b_y_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        xp_q[k] <= cp[k][2*CW-1:FB];
      end
      od_q[0] <= $signed({org_a_x_i[CW-1], org_a_x_i}) - $signed({org_b_x_i[CW-1], org_b_x_i});
      od_q[1] <= $signed({org_a_y_i[CW-1], org_a_y_i}) - $signed({org_b_y_i[CW-1], org_b_y_i});
      od_q[2] <= $signed({org_a_z_i[CW-1], org_a_z_i}) - $signed({org_b_z_i[CW-1], org_b_z_i});
    end
  end

  // Stage 2: cross components
  logic signed [XW-1:0] cz_q, cy_q, cx_q;
  logic signed [DW-1:0] od2_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cz_q <= $signed({xp_q[0][PW-1], xp_q[0]}) - $signed({xp_q[1][PW-1], xp_q[1]});
      cy_q <= $signed({xp_q[2][PW-1], xp_q[2]}) - $signed({xp_q[3][PW-1], xp_q[3]});
      cx_q <= $signed({xp_q[4][PW-1], xp_q[4]}) - $signed({xp_q[5][PW-1], xp_q[5]});
      od2_q <= od_q;
    end
  end

  // Stage 3: pick the denominator and the numerator operands
  logic [XW-1:0] mz, my, mx;
  logic nz_z, nz_y, nz_x;
  lit_pkg::sel_e sel;
  lit_pkg::coord_t opx [4];
  logic signed [DW-1:0] opy [4];
  logic signed [XW-1:0] den;
  lit_pkg::coord_t opx_q [4];
  logic signed [DW-1:0] opy_q [4];
  logic signed [XW-1:0] den3_q;
  lit_pkg::pair_t p2;

  always_comb begin
    p2   = itm_q[1];
    mz   = cz_q[XW-1] ? XW'(-cz_q) : XW'(cz_q);
    my   = cy_q[XW-1] ? XW'(-cy_q) : XW'(cy_q);
    mx   = cx_q[XW-1] ? XW'(-cx_q) : XW'(cx_q);
    nz_z = (cz_q == '0) || (mz < XW'(tol_q));
    nz_y = (cy_q == '0) || (my < XW'(tol_q));
    nz_x = (cx_q == '0) || (mx < XW'(tol_q));
    priority if (!nz_z) begin
      sel = lit_pkg::SEL_Z;
    end else if (!nz_y) begin
      sel = lit_pkg::SEL_Y;
    end else if (!nz_x) begin
      sel = lit_pkg::SEL_X;
    end else begin
      sel = lit_pkg::SEL_PAR;
    end
    unique case (sel)
      lit_pkg::SEL_Y: begin
        opx = '{p2.dbz, p2.dbx, p2.daz, p2.dax};
        opy = '{od2_q[0], od2_q[2], od2_q[0], od2_q[2]};
        den = cy_q;
      end
      lit_pkg::SEL_X: begin
        opx = '{p2.dby, p2.dbz, p2.day, p2.daz};
        opy = '{od2_q[2], od2_q[1], od2_q[2], od2_q[1]};
        den = cx_q;
      end
      default: begin
        opx = '{p2.dbx, p2.dby, p2.dax, p2.day};
        opy = '{od2_q[1], od2_q[0], od2_q[1], od2_q[0]};
        den = cz_q;
      end
    endcase
  end

  // Register the operands and carry the parallel flag to the end
  always_ff @(posedge clk_i) begin
    if (en) begin
      opx_q    <= opx;
      opy_q    <= opy;
      den3_q   <= den;
      par_q[0] <= (sel == lit_pkg::SEL_PAR);
      for (int k = 1; k < PA_N; k++) begin
        par_q[k] <= par_q[k-1];
      end
    end
  end

  // Stage 4: numerator products
  logic signed [CW+DW-1:0] np [4];
  logic [NPW-1:0] np_q [4];
  logic signed [XW-1:0] den4_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      np[k] = opx_q[k] * opy_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        np_q[k] <= np[k][CW+DW-1:FB];
      end
      den4_q <= den3_q;
    end
  end

  // Stage 5: numerators
  logic signed [NW-1:0] n1_q, n2_q;
  logic signed [XW-1:0] den5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q   <= $signed({np_q[0][NPW-1], np_q[0]}) - $signed({np_q[1][NPW-1], np_q[1]});
      n2_q   <= $signed({np_q[2][NPW-1], np_q[2]}) - $signed({np_q[3][NPW-1], np_q[3]});
      den5_q <= den4_q;
    end
  end

  // Divide both numerators by the shared denominator
  lit_pkg::coord_t t1, t2;

  lit_div u_div_a (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (n1_q),
    .den_i (den5_q),
    .quo_o (t1)
  );

  lit_div u_div_b (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (n2_q),
    .den_i (den5_q),
    .quo_o (t2)
  );

  // Post stage 1: rebuild products
  lit_pkg::pair_t pd;
  logic signed [2*CW-1:0] rp [6];
  logic [PW-1:0] rp_q [6];
  lit_pkg::coord_t t1_q [3];
  lit_pkg::coord_t t2_q [3];

  always_comb begin
    pd    = itm_q[DOUT-1];
    rp[0] = pd.dax * t1;
    rp[1] = pd.day * t1;
    rp[2] = pd.daz * t1;
    rp[3] = pd.dbx * t2;
    rp[4] = pd.dby * t2;
    rp[5] = pd.dbz * t2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        rp_q[k] <= rp[k][2*CW-1:FB];
      end
      t1_q[0] <= t1;
      t2_q[0] <= t2;
      for (int k = 1; k < 3; k++) begin
        t1_q[k] <= t1_q[k-1];
        t2_q[k] <= t2_q[k-1];
      end
    end
  end

  // Post stage 2: rebuilt points
  lit_pkg::pair_t pe;
  logic signed [XW-1:0] pt [6];
  logic signed [XW-1:0] pt_q [6];

  always_comb begin
    pe    = itm_q[DOUT];
    pt[0] = XW'(pe.oax) + $signed({rp_q[0][PW-1], rp_q[0]});
    pt[1] = XW'(pe.oay) + $signed({rp_q[1][PW-1], rp_q[1]});
    pt[2] = XW'(pe.oaz) + $signed({rp_q[2][PW-1], rp_q[2]});
    pt[3] = XW'(pe.obx) + $signed({rp_q[3][PW-1], rp_q[3]});
    pt[4] = XW'(pe.oby) + $signed({rp_q[4][PW-1], rp_q[4]});
    pt[5] = XW'(pe.obz) + $signed({rp_q[5][PW-1], rp_q[5]});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q <= pt;
    end
  end

  // Post stage 3: point differences
  logic signed [NW-1:0] dv_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dv_q[k] <= $signed({pt_q[k][XW-1], pt_q[k]})
                 - $signed({pt_q[k+3][XW-1], pt_q[k+3]});
      end
    end
  end

  // Post stage 4: tolerance check and result register
  logic [NW-1:0] dm [3];
  logic hit;
  logic meets_q;
  lit_pkg::coord_t ta_q, tb_q;

  always_comb begin
    hit = !par_q[PA_N-1];
    for (int k = 0; k < 3; k++) begin
      dm[k] = dv_q[k][NW-1] ? NW'(-dv_q[k]) : NW'(dv_q[k]);
      hit   = hit && (dm[k] < NW'(tol_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meets_q <= hit;
      ta_q    <= hit ? t1_q[2] : '0;
      tb_q    <= hit ? t2_q[2] : '0;
    end
  end

  assign meets_o  = meets_q;
  assign time_a_o = ta_q;
  assign time_b_o = tb_q;

  `LIT_ASSERT(a_miss_zero, valid_o && !meets_o |-> time_a_o == '0 && time_b_o == '0, "miss with nonzero time")
  `LIT_ASSERT(a_hold_valid, stall_o |=> $stable(vld_q), "valid bits moved while stalled")
  `LIT_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> vld_q == '0 && !valid_o, "pipeline not empty in reset")

endmodule

### tb/tb_line_intersection_times_unit.sv
module tb_line_intersection_times_unit;

  typedef lit_pkg::coord_t coord_t;
  typedef lit_pkg::pair_t  pair_t;

  localparam int CW   = lit_pkg::CW;
  localparam int FB   = lit_pkg::FB;
  localparam int TOLW = lit_pkg::TOLW;

  typedef logic signed [63:0]  q64_t;
  typedef logic signed [129:0] wide_t;

  typedef struct {
    logic   meets;
    coord_t ta;
    coord_t tb;
  } hit_t;

  typedef struct {
    pair_t p;
    bit    typed;
    hit_t  want;
  } row_t;

  localparam q64_t  Q64_MAX    = 64'sh7fff_ffff_ffff_ffff;
  localparam int    WATCH_LIM  = 3000;
  localparam int    DRAIN_CYC  = 60;
  localparam int    PHASE_ITEMS = 380;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [TOLW-1:0] cfg_data_i = '0;
  logic            valid_i = 1'b0;
  logic            stall_o;
  pair_t           cur = '0;
  logic            valid_o;
  logic            stall_i = 1'b0;
  logic            meets_o;
  coord_t          time_a_o;
  coord_t          time_b_o;

  logic [TOLW-1:0] tol_q = lit_pkg::TOL_RST;
  hit_t            hit_q[$];
  int              errors = 0;
  int              n_sent = 0;
  int              n_hits = 0;
  int              n_got = 0;
  int              quiet_cyc = 0;
  int              stall_left = 0;
  bit              calm = 1'b0;
  row_t            rows[$];

  line_intersection_times_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .valid_i    (valid_i),
    .stall_o    (stall_o),
    .dir_a_x_i  (cur.dax),
    .dir_a_y_i  (cur.day),
    .dir_a_z_i  (cur.daz),
    .org_a_x_i  (cur.oax),
    .org_a_y_i  (cur.oay),
    .org_a_z_i  (cur.oaz),
    .dir_b_x_i  (cur.dbx),
    .dir_b_y_i  (cur.dby),
    .dir_b_z_i  (cur.dbz),
    .org_b_x_i  (cur.obx),
    .org_b_y_i  (cur.oby),
    .org_b_z_i  (cur.obz),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .meets_o    (meets_o),
    .time_a_o   (time_a_o),
    .time_b_o   (time_b_o)
  );

  always #10 clk_i = ~clk_i;

  // Clamp to the symmetric 64-bit range
  function automatic q64_t clamp64(wide_t v);
    wide_t hi;
    hi = Q64_MAX;
    if (v > hi) return Q64_MAX;
    if (v < -hi) return -Q64_MAX;
    return v[63:0];
  endfunction

  function automatic q64_t add_s(q64_t a, q64_t b);
    wide_t w;
    w = a;
    w = w + b;
    return clamp64(w);
  endfunction

  function automatic q64_t sub_s(q64_t a, q64_t b);
    return add_s(a, -b);
  endfunction

  // Floored fixed-point product
  function automatic q64_t fmul(q64_t a, q64_t b);
    wide_t w;
    w = a;
    w = w * b;
    return clamp64(w >>> FB);
  endfunction

  // Truncated fixed-point quotient, clamped to coordinate range
  function automatic coord_t fdiv(q64_t num, q64_t den);
    logic [127:0] un, ud, q, lim;
    bit neg;
    un  = (num < 0) ? 128'(-num) : 128'(num);
    ud  = (den < 0) ? 128'(-den) : 128'(den);
    neg = (num < 0) != (den < 0);
    lim = 128'(1) << (CW - 1);
    q   = (un << FB) / ud;
    if (neg) return (q >= lim) ? coord_t'(lim) : coord_t'(-q);
    return (q >= lim) ? coord_t'(lim - 1) : coord_t'(q);
  endfunction

  function automatic bit tiny(q64_t v, logic [TOLW-1:0] tol);
    q64_t m;
    m = (v < 0) ? -v : v;
    return (v == 0) || (m < q64_t'(tol));
  endfunction

  // Expected meeting result for one line pair
  function automatic hit_t meet_times(pair_t p, logic [TOLW-1:0] tol);
    q64_t na, nb, nc, nd, ne, nf, a, b, c, d, e, f;
    q64_t cz, cy, cx, ad, be, cf, n1, n2, den, t1, t2, dx, dy, dz;
    hit_t r;
    na = p.dax; nb = p.day; nc = p.daz; a = p.oax; b = p.oay; c = p.oaz;
    nd = p.dbx; ne = p.dby; nf = p.dbz; d = p.obx; e = p.oby; f = p.obz;
    r = '{1'b0, '0, '0};
    cz = sub_s(fmul(na, ne), fmul(nb, nd));
    cy = sub_s(fmul(nc, nd), fmul(na, nf));
    cx = sub_s(fmul(nb, nf), fmul(nc, ne));
    ad = sub_s(a, d); be = sub_s(b, e); cf = sub_s(c, f);
    if (!tiny(cz, tol)) begin
      den = cz;
      n1 = sub_s(fmul(nd, be), fmul(ne, ad));
      n2 = sub_s(fmul(na, be), fmul(nb, ad));
    end else if (!tiny(cy, tol)) begin
      den = cy;
      n1 = sub_s(fmul(nf, ad), fmul(nd, cf));
      n2 = sub_s(fmul(nc, ad), fmul(na, cf));
    end else if (!tiny(cx, tol)) begin
      den = cx;
      n1 = sub_s(fmul(ne, cf), fmul(nf, be));
      n2 = sub_s(fmul(nb, cf), fmul(nc, be));
    end else begin
      return r;
    end
    t1 = fdiv(n1, den);
    t2 = fdiv(n2, den);
    dx = sub_s(add_s(a, fmul(na, t1)), add_s(d, fmul(nd, t2)));
    dy = sub_s(add_s(b, fmul(nb, t1)), add_s(e, fmul(ne, t2)));
    dz = sub_s(add_s(c, fmul(nc, t1)), add_s(f, fmul(nf, t2)));
    dx = (dx < 0) ? -dx : dx;
    dy = (dy < 0) ? -dy : dy;
    dz = (dz < 0) ? -dz : dz;
    if (dx < q64_t'(tol) && dy < q64_t'(tol) && dz < q64_t'(tol)) begin
      r.meets = 1'b1;
      r.ta = t1[CW-1:0];
      r.tb = t2[CW-1:0];
    end
    return r;
  endfunction

  function automatic coord_t qi(int v);
    return coord_t'(v) <<< FB;
  endfunction

  function automatic pair_t mk(coord_t a0, a1, a2, o0, o1, o2, b0, b1, b2, p0, p1, p2);
    pair_t p;
    p = '{a0, a1, a2, o0, o1, o2, b0, b1, b2, p0, p1, p2};
    return p;
  endfunction

  function automatic coord_t rnd_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t rnd_small(int span);
    return coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
  endfunction

  // Build a pair that meets at a chosen point, with random content
  function automatic pair_t rnd_meeting();
    pair_t p;
    coord_t px, py, pz, ta, tb;
    int kind;
    px = rnd_small(1 << 22); py = rnd_small(1 << 22); pz = rnd_small(1 << 22);
    ta = rnd_small(1 << 20); tb = rnd_small(1 << 20);
    p.dax = rnd_small(1 << 19); p.day = rnd_small(1 << 19); p.daz = rnd_small(1 << 19);
    p.dbx = rnd_small(1 << 19); p.dby = rnd_small(1 << 19); p.dbz = rnd_small(1 << 19);
    kind = $urandom_range(0, 5);
    // Push the denominator onto the y or x fallback now and then
    if (kind == 0) begin
      p.day = '0; p.dby = '0;
    end else if (kind == 1) begin
      p.dax = '0; p.dbx = '0;
    end
    p.oax = px - coord_t'((64'(p.dax) * 64'(ta)) >>> FB);
    p.oay = py - coord_t'((64'(p.day) * 64'(ta)) >>> FB);
    p.oaz = pz - coord_t'((64'(p.daz) * 64'(ta)) >>> FB);
    p.obx = px - coord_t'((64'(p.dbx) * 64'(tb)) >>> FB);
    p.oby = py - coord_t'((64'(p.dby) * 64'(tb)) >>> FB);
    p.obz = pz - coord_t'((64'(p.dbz) * 64'(tb)) >>> FB);
    // Break a few of them by one coordinate
    if ($urandom_range(0, 7) == 0) p.obz = p.obz + rnd_small(1 << 18);
    return p;
  endfunction

  function automatic pair_t rnd_pair();
    pair_t p;
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return rnd_meeting();
    p = mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
           rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    // Parallel directions with random origins
    if (k == 9) begin
      p.dbx = p.dax; p.dby = p.day; p.dbz = p.daz;
    end
    return p;
  endfunction

  // Hand one pair to the block, with an optional idle burst first
  task automatic send_pair(pair_t p, bit typed, hit_t want);
    if (!calm && $urandom_range(0, 5) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    cur     <= p;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    hit_q.push_back(typed ? want : meet_times(p, tol_q));
    n_sent++;
  endtask

  // Write tolerance once every result is home
  task automatic set_tolerance(logic [TOLW-1:0] v);
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (hit_q.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tol_q = v;
  endtask

  task automatic run_random(int count);
    hit_t none;
    none = '{1'b0, '0, '0};
    repeat (count) send_pair(rnd_pair(), 1'b0, none);
  endtask

  // Receive side: stall bursts and result checks
  always @(posedge clk_i) begin
    hit_t w;
    int   n;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        n_got++;
        if (hit_q.size() == 0) begin
          $error("result with no transfer waiting");
          errors++;
        end else begin
          w = hit_q.pop_front();
          if (w.meets) n_hits++;
          if (meets_o !== w.meets) begin
            $error("meets: expected %0d, got %0d", w.meets, meets_o);
            errors++;
          end
          if (time_a_o !== w.ta) begin
            $error("time_a: expected %0d, got %0d", w.ta, time_a_o);
            errors++;
          end
          if (time_b_o !== w.tb) begin
            $error("time_b: expected %0d, got %0d", w.tb, time_b_o);
            errors++;
          end
        end
      end
      n = stall_left;
      if (n != 0) n--;
      else if (!calm && $urandom_range(0, 9) == 0) n = $urandom_range(1, 12);
      stall_left = n;
      stall_i <= (n != 0);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet_cyc = 0;
      else quiet_cyc++;
      if (quiet_cyc >= WATCH_LIM) begin
        $display("tb_line_intersection_times_unit failed");
        $finish;
      end
    end
  end

  initial begin
    hit_t none, h;
    none = '{1'b0, '0, '0};
    // Directed rows: typed expectations where obvious
    rows.push_back('{mk('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b1, none});
    h = '{1'b1, qi(2), qi(3)};
    rows.push_back('{mk(qi(1), '0, '0, '0, '0, '0, '0, qi(1), '0, qi(2), qi(-3), '0),
                     1'b1, h});
    rows.push_back('{mk(qi(1), '0, '0, '0, '0, '0, '0, '0, qi(1), qi(2), '0, qi(-3)),
                     1'b0, none});
    rows.push_back('{mk('0, qi(1), '0, '0, '0, '0, '0, '0, qi(1), '0, qi(2), qi(-3)),
                     1'b0, none});
    rows.push_back('{mk(qi(1), '0, '0, '0, '0, '0, '0, qi(1), '0, '0, '0, qi(5)),
                     1'b1, none});
    rows.push_back('{mk(qi(1), qi(2), qi(3), '0, '0, '0, qi(1), qi(2), qi(3), qi(4), '0, '0),
                     1'b1, none});
    rows.push_back('{pair_t'({12{32'sh7fff_ffff}}), 1'b0, none});
    rows.push_back('{pair_t'({12{32'sh8000_0000}}), 1'b0, none});
    rows.push_back('{mk(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                        32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                        32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff),
                     1'b0, none});
    rows.push_back('{mk(qi(1), '0, '0, '0, '0, '0, qi(1), 32'sd20, '0, qi(-30000),
                        qi(30000), '0), 1'b0, none});
    rows.push_back('{mk(32'sd1, '0, '0, '0, '0, '0, '0, 32'sd1, '0, '0, '0, '0),
                     1'b0, none});
    rows.push_back('{mk(qi(-3), qi(2), qi(1), qi(7), qi(-1), qi(4), qi(2), qi(5), qi(-2),
                        qi(-6), qi(3), qi(9)), 1'b0, none});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset tolerance
    foreach (rows[i]) send_pair(rows[i].p, rows[i].typed, rows[i].want);
    run_random(PHASE_ITEMS);
    // Zero tolerance: no pair can meet
    set_tolerance('0);
    rows[1].want = none;
    send_pair(rows[1].p, 1'b1, none);
    run_random(PHASE_ITEMS);
    set_tolerance('1);
    run_random(PHASE_ITEMS);
    set_tolerance(16'd1);
    run_random(PHASE_ITEMS);
    set_tolerance(16'($urandom_range(2, 4096)));
    run_random(PHASE_ITEMS / 2);
    // Last stretch without idling on either side
    calm = 1'b1;
    run_random(PHASE_ITEMS / 2);
    valid_i <= 1'b0;

    while (hit_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("%0d line pairs sent over five tolerance settings, %0d results checked",
             n_sent, n_got);
    $display("%0d of them met, the rest parallel or skew", n_hits);
    if (errors == 0) begin
      $display("tb_line_intersection_times_unit passed");
    end else begin
      $display("tb_line_intersection_times_unit failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/lit_pkg.sv
sv/lit_div.sv
sv/line_intersection_times_unit.sv
tb/tb_line_intersection_times_unit.sv
